FILE: rtl/bpa_pkg.sv
// bpa_pkg: shared constants, types and state codes of the buddy page allocator
// no dependencies
package bpa_pkg;

  localparam int NUM_FRAMES  = 1024;
  localparam int NUM_ORDERS  = 6;
  localparam int FRAME_BYTES = 4096;

  localparam int PAGE_SHIFT = $clog2(FRAME_BYTES);
  localparam int IDX_W      = $clog2(NUM_FRAMES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ORD_W      = 3;
  localparam int SPAN       = 1 << (NUM_ORDERS - 1);
  localparam int TILED      = (NUM_FRAMES / SPAN) * SPAN;
  localparam logic [31:0] MAX_BYTES = 32'(FRAME_BYTES) << (NUM_ORDERS - 1);

  // register index taken from paddr[2]
  localparam logic REG_REGION_BASE = 1'b0;

  typedef enum logic [1:0] {
    KIND_INTERIOR = 2'd0,
    KIND_FREE     = 2'd1,
    KIND_ALLOC    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_BLOCK  = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef struct packed {
    kind_t            kind;
    logic [ORD_W-1:0] order;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_DECIDE,
    S_A_SPLIT,
    S_F_ADDR,
    S_F_HEAD,
    S_F_STEP,
    S_F_BCHK,
    S_F_FIN,
    S_RESP
  } state_t;

endpackage

FILE: rtl/bpa_if.sv
// bpa_if: request and result channel interfaces
// depends on nothing
interface bpa_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] request_bytes;
  logic [31:0] free_address;
  modport source(output valid, mode, request_bytes, free_address, input ready);
  modport sink(input valid, mode, request_bytes, free_address, output ready);
endinterface

interface bpa_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] block_address;
  logic [2:0]  block_order;
  modport source(output valid, status, block_address, block_order, input ready);
  modport sink(input valid, status, block_address, block_order, output ready);
endinterface

FILE: rtl/bpa_ram.sv
// bpa_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

FILE: rtl/bpa_cfg.sv
// bpa_cfg: apb-style register port holding region_base
// depends on bpa_pkg
module bpa_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] region_base
);
  logic [31:0] region_base_r;
  logic [31:0] region_base_nxt;

  always_comb begin
    region_base_nxt = region_base_r;
    if (psel && penable && pwrite && (paddr[2] == bpa_pkg::REG_REGION_BASE)) begin
      region_base_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r <= '0;
    end else begin
      region_base_r <= region_base_nxt;
    end
  end

  assign prdata      = (paddr[2] == bpa_pkg::REG_REGION_BASE) ? region_base_r : '0;
  assign pready      = 1'b1;
  assign region_base = region_base_r;
endmodule

FILE: rtl/bpa_core.sv
// bpa_core: sequencer that walks frame state for allocate and free requests
// depends on bpa_pkg, bpa_if
module bpa_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [31:0]                   region_base,
  bpa_in_if.sink                        in_ch,
  bpa_out_if.source                     out_ch,
  output bpa_pkg::ram_req_t             ram_req,
  input  logic [bpa_pkg::ENTRY_W-1:0]   ram_rdata
);
  localparam int IDX_W = bpa_pkg::IDX_W;
  localparam int CNT_W = bpa_pkg::CNT_W;
  localparam int ORD_W = bpa_pkg::ORD_W;
  localparam int PS    = bpa_pkg::PAGE_SHIFT;

  bpa_pkg::state_t  state_r, state_nxt;
  logic [CNT_W-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0] walk_r, walk_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] buddy_r, buddy_nxt;
  logic [ORD_W-1:0] ord_r, ord_nxt;
  logic [ORD_W-1:0] want_r, want_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [ORD_W-1:0] best_ord_r, best_ord_nxt;
  logic [31:0]      off_r, off_nxt;
  bpa_pkg::status_t res_status_r, res_status_nxt;
  logic [31:0]      res_addr_r, res_addr_nxt;
  logic [ORD_W-1:0] res_ord_r, res_ord_nxt;
  logic             out_valid_r, out_valid_nxt;
  bpa_pkg::status_t out_status_r, out_status_nxt;
  logic [31:0]      out_addr_r, out_addr_nxt;
  logic [ORD_W-1:0] out_ord_r, out_ord_nxt;

  bpa_pkg::entry_t  rd;
  logic [ORD_W-1:0] want_c;
  logic [CNT_W-1:0] walk_add;
  logic [IDX_W-1:0] buddy_c;
  logic [31:0]      idx_addr;

  assign rd       = bpa_pkg::entry_t'(ram_rdata);
  assign walk_add = walk_r + (CNT_W'(1) << rd.order);
  assign buddy_c  = idx_r ^ (IDX_W'(1) << ord_r);
  assign idx_addr = region_base + (32'(idx_r) << PS);

  // smallest order whose block holds the request
  always_comb begin
    want_c = '0;
    for (int w = 0; w < bpa_pkg::NUM_ORDERS - 1; w++) begin
      want_c = want_c + ORD_W'((32'(bpa_pkg::FRAME_BYTES) << w) < in_ch.request_bytes);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    walk_nxt       = walk_r;
    idx_nxt        = idx_r;
    buddy_nxt      = buddy_r;
    ord_nxt        = ord_r;
    want_nxt       = want_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_ord_nxt   = best_ord_r;
    off_nxt        = off_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_ord_nxt    = res_ord_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_ord_nxt    = out_ord_r;
    ram_req        = '0;

    case (state_r)
      bpa_pkg::S_CLEAR: begin
        ram_req.we          = 1'b1;
        ram_req.waddr       = clr_r[IDX_W-1:0];
        ram_req.wdata.order = ORD_W'(bpa_pkg::NUM_ORDERS - 1);
        ram_req.wdata.kind  = ((clr_r & CNT_W'(bpa_pkg::SPAN - 1)) == '0 &&
                               clr_r < CNT_W'(bpa_pkg::TILED)) ?
                              bpa_pkg::KIND_FREE : bpa_pkg::KIND_INTERIOR;
        clr_nxt = clr_r + CNT_W'(1);
        if (clr_r == CNT_W'(bpa_pkg::NUM_FRAMES - 1)) begin
          state_nxt = bpa_pkg::S_IDLE;
        end
      end
      bpa_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          if (!in_ch.mode) begin
            if (in_ch.request_bytes > bpa_pkg::MAX_BYTES) begin
              res_status_nxt = bpa_pkg::ST_TOO_LARGE;
              res_addr_nxt   = '0;
              res_ord_nxt    = '0;
              state_nxt      = bpa_pkg::S_RESP;
            end else begin
              want_nxt  = want_c;
              walk_nxt  = '0;
              found_nxt = 1'b0;
              state_nxt = bpa_pkg::S_A_RD;
            end
          end else begin
            off_nxt   = in_ch.free_address - region_base;
            state_nxt = bpa_pkg::S_F_ADDR;
          end
        end
      end
      bpa_pkg::S_A_RD: begin
        ram_req.raddr = walk_r[IDX_W-1:0];
        state_nxt     = bpa_pkg::S_A_CHK;
      end
      bpa_pkg::S_A_CHK: begin
        if (rd.kind == bpa_pkg::KIND_FREE && rd.order >= want_r &&
            (!found_r || rd.order < best_ord_r)) begin
          found_nxt    = 1'b1;
          best_idx_nxt = walk_r[IDX_W-1:0];
          best_ord_nxt = rd.order;
        end
        walk_nxt  = walk_add;
        state_nxt = (walk_add >= CNT_W'(bpa_pkg::TILED)) ?
                    bpa_pkg::S_A_DECIDE : bpa_pkg::S_A_RD;
      end
      bpa_pkg::S_A_DECIDE: begin
        if (found_r) begin
          idx_nxt   = best_idx_r;
          ord_nxt   = best_ord_r;
          state_nxt = bpa_pkg::S_A_SPLIT;
        end else begin
          res_status_nxt = bpa_pkg::ST_NO_BLOCK;
          res_addr_nxt   = '0;
          res_ord_nxt    = '0;
          state_nxt      = bpa_pkg::S_RESP;
        end
      end
      bpa_pkg::S_A_SPLIT: begin
        ram_req.we = 1'b1;
        if (ord_r > want_r) begin
          // free the right half, keep splitting the left
          ram_req.waddr       = idx_r + (IDX_W'(1) << (ord_r - ORD_W'(1)));
          ram_req.wdata.kind  = bpa_pkg::KIND_FREE;
          ram_req.wdata.order = ord_r - ORD_W'(1);
          ord_nxt             = ord_r - ORD_W'(1);
        end else begin
          ram_req.waddr       = idx_r;
          ram_req.wdata.kind  = bpa_pkg::KIND_ALLOC;
          ram_req.wdata.order = want_r;
          res_status_nxt      = bpa_pkg::ST_OK;
          res_addr_nxt        = idx_addr;
          res_ord_nxt         = want_r;
          state_nxt           = bpa_pkg::S_RESP;
        end
      end
      bpa_pkg::S_F_ADDR: begin
        if (off_r[PS-1:0] != '0 ||
            off_r[31:PS] >= (32-PS)'(bpa_pkg::NUM_FRAMES)) begin
          res_status_nxt = bpa_pkg::ST_BAD_FREE;
          res_addr_nxt   = '0;
          res_ord_nxt    = '0;
          state_nxt      = bpa_pkg::S_RESP;
        end else begin
          idx_nxt       = off_r[PS+IDX_W-1:PS];
          ram_req.raddr = off_r[PS+IDX_W-1:PS];
          state_nxt     = bpa_pkg::S_F_HEAD;
        end
      end
      bpa_pkg::S_F_HEAD: begin
        if (rd.kind != bpa_pkg::KIND_ALLOC) begin
          res_status_nxt = bpa_pkg::ST_BAD_FREE;
          res_addr_nxt   = '0;
          res_ord_nxt    = '0;
          state_nxt      = bpa_pkg::S_RESP;
        end else begin
          ord_nxt   = rd.order;
          state_nxt = bpa_pkg::S_F_STEP;
        end
      end
      bpa_pkg::S_F_STEP: begin
        if (ord_r < ORD_W'(bpa_pkg::NUM_ORDERS - 1) &&
            {1'b0, buddy_c} < CNT_W'(bpa_pkg::NUM_FRAMES)) begin
          ram_req.raddr = buddy_c;
          buddy_nxt     = buddy_c;
          state_nxt     = bpa_pkg::S_F_BCHK;
        end else begin
          state_nxt = bpa_pkg::S_F_FIN;
        end
      end
      bpa_pkg::S_F_BCHK: begin
        if (rd.kind == bpa_pkg::KIND_FREE && rd.order == ord_r) begin
          // the upper half of the pair becomes interior
          ram_req.we          = 1'b1;
          ram_req.waddr       = (buddy_r > idx_r) ? buddy_r : idx_r;
          ram_req.wdata.kind  = bpa_pkg::KIND_INTERIOR;
          ram_req.wdata.order = ord_r;
          idx_nxt             = (buddy_r < idx_r) ? buddy_r : idx_r;
          ord_nxt             = ord_r + ORD_W'(1);
          state_nxt           = bpa_pkg::S_F_STEP;
        end else begin
          state_nxt = bpa_pkg::S_F_FIN;
        end
      end
      bpa_pkg::S_F_FIN: begin
        ram_req.we          = 1'b1;
        ram_req.waddr       = idx_r;
        ram_req.wdata.kind  = bpa_pkg::KIND_FREE;
        ram_req.wdata.order = ord_r;
        res_status_nxt      = bpa_pkg::ST_OK;
        res_addr_nxt        = idx_addr;
        res_ord_nxt         = ord_r;
        state_nxt           = bpa_pkg::S_RESP;
      end
      bpa_pkg::S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          out_ord_nxt    = res_ord_r;
          state_nxt      = bpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bpa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r       <= walk_nxt;
    idx_r        <= idx_nxt;
    buddy_r      <= buddy_nxt;
    ord_r        <= ord_nxt;
    want_r       <= want_nxt;
    found_r      <= found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_ord_r   <= best_ord_nxt;
    off_r        <= off_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_ord_r    <= res_ord_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_ord_r    <= out_ord_nxt;
  end

  assign in_ch.ready          = (state_r == bpa_pkg::S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.block_address = out_addr_r;
  assign out_ch.block_order   = out_ord_r;

  // frame state is never touched while waiting for a request
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bpa_pkg::S_IDLE |-> !ram_req.we)
    else $error("frame write while idle");

  // an error beat carries zero address and order
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != bpa_pkg::ST_OK |-> out_addr_r == '0 && out_ord_r == '0)
    else $error("error beat with nonzero payload");

  // returned orders stay within the largest block
  a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_ord_r <= ORD_W'(bpa_pkg::NUM_ORDERS - 1))
    else $error("order out of range");
endmodule

FILE: rtl/buddy_page_allocator.sv
// buddy_page_allocator: top level, ties register port, sequencer and frame ram
// depends on bpa_pkg, bpa_if, bpa_ram, bpa_cfg, bpa_core
//
// buddy allocator over 1024 frames of 4 KiB starting at region_base, orders 0..5.
// after reset a clearing pass writes the initial frame state; in_ch.ready
// stays low meanwhile, register writes are taken as ever. one request is worked
// at a time. an allocate walks the block heads of the region in frame order
// through the single read port of the frame ram, then writes one split per
// cycle. a free checks the address, then the head frame, merges with a free
// buddy of equal order as long as it can and writes the merged block free; a
// rejected free stops at the address or head check. the result beat sits in an
// output register, so the next request is taken while it waits.
module buddy_page_allocator (
  input  logic        clk,
  input  logic        rst_n,
  bpa_in_if.sink      in_ch,
  bpa_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [31:0]                     region_base;
  bpa_pkg::ram_req_t               ram_req;
  logic [bpa_pkg::ENTRY_W-1:0]     ram_rdata;

  // region_base register
  bpa_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .region_base (region_base)
  );

  // search, split and merge sequencer
  bpa_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .region_base (region_base),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata)
  );

  // per-frame kind and order
  bpa_ram #(
    .WIDTH (bpa_pkg::ENTRY_W),
    .DEPTH (bpa_pkg::NUM_FRAMES)
  ) u_frames (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );
endmodule
